/* hdl/mcho_pkg.sv */
package mcho_pkg;

  // Sizes
  localparam int BUFFER_DEPTH     = 4096;
  localparam int MAX_VOICES       = 6;
  localparam int PHASE_BITS       = 24;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_SPREAD     = 6;

  localparam int ADDR_W      = $clog2(BUFFER_DEPTH);
  localparam int SINE_IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int QUART_W     = SINE_IDX_W - 2;
  localparam int QUART_DEPTH = SINE_TABLE_DEPTH / 4;
  localparam int VIDX_W      = $clog2(MAX_VOICES);
  localparam int FRAC_W      = 8;
  localparam int POS_W       = ADDR_W + FRAC_W;

  // Field and register widths
  localparam int SAMPLE_W = 16;
  localparam int VCOUNT_W = 3;
  localparam int DEPTH_W  = 20;
  localparam int MIX_W    = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // Voice sum: one voice spans SAMPLE_W + FRAC_W bits, six of them add three
  localparam int ACC_W = SAMPLE_W + FRAC_W + 3;

  localparam int VOICE_MIN = 2;
  localparam int VOICE_MAX = (MAX_VOICES < 6) ? MAX_VOICES : 6;
  localparam int DEPTH_MAX = (BUFFER_DEPTH - 2) * 256;
  localparam int MIX_ONE   = 32768;

  // Reset values of the registers
  localparam int RST_VOICE_COUNT = 3;
  localparam int RST_PHASE_STEP  = 350;
  localparam int RST_DEPTH_DELAY = 36864;
  localparam int RST_WET_MIX     = 16384;

  // Ceiling reciprocals 2^23 / V for the voice count, exact for quotients below 2^19
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] MIX_RECIP [8] = '{
    23'd0, 23'd0, 23'd4194304, 23'd2796203, 23'd2097152, 23'd1677722, 23'd1398102, 23'd0
  };

  typedef enum logic [1:0] {
    REG_VOICE_COUNT,
    REG_PHASE_STEP,
    REG_DEPTH_DELAY,
    REG_WET_MIX
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOICE,
    ST_DRAIN,
    ST_MIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry;
    logic signed [ACC_W-1:0]    sum;
    logic [VCOUNT_W-1:0]        voices;
    logic [MIX_W-1:0]           mix;
  } mix_req_t;

  typedef logic [SAMPLE_W-2:0] qsine_lut_t [QUART_DEPTH];
  typedef logic [PHASE_BITS-1:0] phase_init_t [MAX_VOICES];

  // Quarter-wave polynomial sine magnitude, Q1.15, for t in Q16 (0..65536)
  function automatic longint sine_quarter(longint t);
    longint t2, r, s;
    t2 = (t * t) >>> 16;
    r = 5223 - ((307 * t2) >>> 16);
    r = 42334 - ((r * t2) >>> 16);
    r = 102944 - ((r * t2) >>> 16);
    s = (r * t + 65536) >>> 17;
    if (s > 32767) begin
      s = 32767;
    end
    return s;
  endfunction

  // First quadrant only; the other three follow by mirror and sign
  function automatic qsine_lut_t qsine_build();
    qsine_lut_t lut;
    for (int i = 0; i < QUART_DEPTH; i++) begin
      lut[i] = (SAMPLE_W-1)'(sine_quarter((longint'(i) * 4 * 65536) / SINE_TABLE_DEPTH));
    end
    return lut;
  endfunction

  function automatic phase_init_t phase_init_build();
    phase_init_t init;
    for (int i = 0; i < MAX_VOICES; i++) begin
      init[i] = PHASE_BITS'((longint'(i) << PHASE_BITS) / PHASE_SPREAD);
    end
    return init;
  endfunction

  localparam qsine_lut_t          QSINE_LUT  = qsine_build();
  localparam logic [SAMPLE_W-2:0] SINE_PEAK  = (SAMPLE_W-1)'(sine_quarter(65536));
  localparam phase_init_t         PHASE_INIT = phase_init_build();

endpackage

/* hdl/mcho_ram.sv */
module mcho_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

/* hdl/mcho_mix.sv */
module mcho_mix (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  mcho_pkg::mix_req_t                req,
  output logic                              done,
  output logic signed [mcho_pkg::SAMPLE_W-1:0] result
);
  import mcho_pkg::*;

  localparam int A_W    = SAMPLE_W + MIX_W + 2;
  localparam int B_W    = ACC_W + MIX_W + 1;
  localparam int AV_W   = A_W + VCOUNT_W + 1;
  localparam int N_W    = 46;
  localparam int Y_W    = N_W - RECIP_SHIFT;
  localparam int YOFF_W = 19;
  localparam int PROD_W = YOFF_W + RECIP_W;

  logic [4:0] stage_valid;

  logic signed [A_W-1:0]  a_q;
  logic signed [B_W-1:0]  b_q;
  logic [VCOUNT_W-1:0]    voices_q;
  logic signed [Y_W-1:0]  y_q;
  logic [YOFF_W-1:0]      yoff_q;
  logic                   sat_hi_q, sat_lo_q, sat_hi2_q, sat_lo2_q;
  logic [SAMPLE_W-1:0]    quot_q;

  logic [MIX_W:0]         dry_gain;
  logic signed [AV_W-1:0] av;
  logic signed [N_W-1:0]  av_ext, half_ext, num;
  logic signed [Y_W-1:0]  lim, yoff;
  logic [PROD_W-1:0]      quot_prod;

  assign dry_gain  = (MIX_W + 1)'(MIX_ONE) - {1'b0, req.mix};
  assign av        = a_q * $signed({1'b0, voices_q});
  assign av_ext    = N_W'(av) <<< FRAC_W;
  assign half_ext  = $signed(N_W'({voices_q, 22'b0}));
  assign num       = av_ext + N_W'(b_q) + half_ext;
  assign lim       = $signed(Y_W'({voices_q, 15'b0}));
  assign yoff      = y_q + lim;
  assign quot_prod = yoff_q * MIX_RECIP[voices_q];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= {stage_valid[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q      <= req.dry * $signed({1'b0, dry_gain});
      b_q      <= req.sum * $signed({1'b0, req.mix});
      voices_q <= req.voices;
    end
    if (stage_valid[0]) begin
      // floor by 2^23 first, then by the voice count
      y_q <= num[N_W-1:RECIP_SHIFT];
    end
    if (stage_valid[1]) begin
      sat_hi_q <= (y_q >= lim);
      sat_lo_q <= (y_q < -lim);
      yoff_q   <= yoff[YOFF_W-1:0];
    end
    if (stage_valid[2]) begin
      quot_q    <= quot_prod[RECIP_SHIFT +: SAMPLE_W];
      sat_hi2_q <= sat_hi_q;
      sat_lo2_q <= sat_lo_q;
    end
    if (stage_valid[3]) begin
      if (sat_hi2_q) begin
        result <= $signed({1'b0, {(SAMPLE_W-1){1'b1}}});
      end else if (sat_lo2_q) begin
        result <= $signed({1'b1, {(SAMPLE_W-1){1'b0}}});
      end else begin
        // remove the offset of 32768 added before the divide
        result <= $signed({~quot_q[SAMPLE_W-1], quot_q[SAMPLE_W-2:0]});
      end
    end
  end

  assign done = stage_valid[4];

endmodule

/* hdl/multi_voice_chorus_top.sv */
// An accepted item passes the per-voice stage, which takes one voice a cycle for V = active
// voices (2..6), then the delay-store read path drains and the mix divider runs; a new item
// is accepted only once the previous one has left the mix divider.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active high) restores registers, phases and write pointer at once;
// the delay store reads as zero until each entry is first written.
module multi_voice_chorus_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mcho_pkg::PADDR_W-1:0]         paddr,
  input  logic [mcho_pkg::PDATA_W-1:0]         pwdata,
  output logic [mcho_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mcho_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mcho_pkg::SAMPLE_W-1:0] sample_out
);
  import mcho_pkg::*;

  // Configuration registers
  logic [VCOUNT_W-1:0]   voice_count;
  logic [PHASE_BITS-1:0] phase_step;
  logic [DEPTH_W-1:0]    depth_delay;
  logic [MIX_W-1:0]      wet_mix;

  logic [VCOUNT_W-1:0]   voices;
  logic [DEPTH_W-1:0]    depth_lim;
  logic [MIX_W-1:0]      mix_lim;
  logic                  cfg_write;
  reg_idx_t              cfg_idx;

  // Control
  state_t                state, state_next;
  logic                  in_fire, voice_issue, mix_start, out_load, slot_free;
  logic                  pipe_empty, vcnt_last, mix_done;
  logic [VIDX_W-1:0]     vcnt;
  logic [ADDR_W-1:0]     wp;
  logic                  wrapped;
  logic [PHASE_BITS-1:0] voice_phase [MAX_VOICES];

  // Voice path
  logic                        s0_valid, s1_valid, s2_valid;
  logic [PHASE_BITS-1:0]       phase_cur;
  logic [SINE_IDX_W-1:0]       sine_idx;
  logic [QUART_W-1:0]          quart_pos, quart_idx;
  logic [SAMPLE_W-2:0]         sine_mag;
  logic signed [SAMPLE_W-1:0]  sine_s;
  logic [SAMPLE_W-1:0]         sine_off;
  logic [DEPTH_W+SAMPLE_W-1:0] dly_prod;
  logic [DEPTH_W-1:0]          dly_q;
  logic [POS_W-1:0]            pos;
  logic [ADDR_W-1:0]           idx0, idx1;
  logic [FRAC_W-1:0]           frac_q;
  logic                        ok0_q, ok1_q;
  logic [SAMPLE_W-1:0]         rdata0, rdata1;
  logic signed [SAMPLE_W-1:0]  st0, st1;
  logic signed [SAMPLE_W:0]    diff;
  logic signed [SAMPLE_W+FRAC_W+1:0] ip_prod, prod_q;
  logic signed [SAMPLE_W+FRAC_W-1:0] base_q;
  logic signed [ACC_W-1:0]     acc;
  logic signed [SAMPLE_W-1:0]  dry_q;
  logic signed [SAMPLE_W-1:0]  mix_result;
  mix_req_t                    mix_req;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_count <= VCOUNT_W'(RST_VOICE_COUNT);
      phase_step  <= PHASE_BITS'(RST_PHASE_STEP);
      depth_delay <= DEPTH_W'(RST_DEPTH_DELAY);
      wet_mix     <= MIX_W'(RST_WET_MIX);
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_VOICE_COUNT: voice_count <= pwdata[VCOUNT_W-1:0];
        REG_PHASE_STEP:  phase_step  <= pwdata[PHASE_BITS-1:0];
        REG_DEPTH_DELAY: depth_delay <= pwdata[DEPTH_W-1:0];
        REG_WET_MIX:     wet_mix     <= pwdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_VOICE_COUNT: prdata = PDATA_W'(voice_count);
      REG_PHASE_STEP:  prdata = PDATA_W'(phase_step);
      REG_DEPTH_DELAY: prdata = PDATA_W'(depth_delay);
      REG_WET_MIX:     prdata = PDATA_W'(wet_mix);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    if (voice_count < VCOUNT_W'(VOICE_MIN)) begin
      voices = VCOUNT_W'(VOICE_MIN);
    end else if (voice_count > VCOUNT_W'(VOICE_MAX)) begin
      voices = VCOUNT_W'(VOICE_MAX);
    end else begin
      voices = voice_count;
    end
  end

  assign depth_lim = (depth_delay > DEPTH_W'(DEPTH_MAX)) ? DEPTH_W'(DEPTH_MAX) : depth_delay;
  assign mix_lim   = (wet_mix > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : wet_mix;

  // Sequencer
  assign in_fire    = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign pipe_empty = !s0_valid && !s1_valid && !s2_valid;
  assign vcnt_last  = (VCOUNT_W'(vcnt) == voices - VCOUNT_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_VOICE;
      ST_VOICE: if (vcnt_last) state_next = ST_DRAIN;
      ST_DRAIN: if (pipe_empty) state_next = ST_MIX;
      ST_MIX: begin
        if (mix_done) begin
          state_next = slot_free ? ST_IDLE : ST_OUT;
        end
      end
      ST_OUT:   if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    voice_issue = 1'b0;
    mix_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE:  in_ready    = 1'b1;
      ST_VOICE: voice_issue = 1'b1;
      ST_DRAIN: mix_start   = pipe_empty;
      ST_MIX:   out_load    = mix_done && slot_free;
      ST_OUT:   out_load    = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vcnt      <= '0;
      wp        <= '0;
      wrapped   <= 1'b0;
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        voice_phase[i] <= PHASE_INIT[i];
      end
    end else begin
      state    <= state_next;
      s0_valid <= voice_issue;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      if (in_fire) begin
        vcnt <= '0;
      end else if (voice_issue) begin
        vcnt <= vcnt + VIDX_W'(1);
      end
      // advance each phase as its voice is read, once per item
      if (voice_issue) begin
        voice_phase[vcnt] <= voice_phase[vcnt] + phase_step;
      end
      if (mix_start) begin
        wp <= wp + ADDR_W'(1);
        if (wp == ADDR_W'(BUFFER_DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage 0: sine lookup and delay
  assign phase_cur = voice_phase[vcnt];
  assign sine_idx  = phase_cur[PHASE_BITS-1 -: SINE_IDX_W];
  assign quart_pos = sine_idx[QUART_W-1:0];
  // mirror the falling quadrants; their first entry is the peak just past the table
  assign quart_idx = sine_idx[QUART_W] ? QUART_W'(0) - quart_pos : quart_pos;
  assign sine_mag  = (sine_idx[QUART_W] && quart_pos == '0) ? SINE_PEAK
                                                             : QSINE_LUT[quart_idx];
  assign sine_s    = sine_idx[SINE_IDX_W-1] ? -$signed({1'b0, sine_mag})
                                            : $signed({1'b0, sine_mag});
  assign sine_off  = {~sine_s[SAMPLE_W-1], sine_s[SAMPLE_W-2:0]};
  assign dly_prod  = depth_lim * sine_off;

  // Stage 1: read position, wrapping below zero falls out of the modular subtract
  assign pos  = {wp, FRAC_W'(0)} - POS_W'(dly_q);
  assign idx0 = pos[POS_W-1:FRAC_W];
  assign idx1 = idx0 + ADDR_W'(1);

  // Stage 2: interpolate as st0*256 + (st1 - st0)*f; unwritten entries read as zero
  assign st0     = ok0_q ? $signed(rdata0) : '0;
  assign st1     = ok1_q ? $signed(rdata1) : '0;
  assign diff    = (SAMPLE_W + 1)'(st1) - (SAMPLE_W + 1)'(st0);
  assign ip_prod = diff * $signed({1'b0, frac_q});

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dry_q <= sample_in;
    end
    if (voice_issue) begin
      dly_q <= dly_prod[DEPTH_W+SAMPLE_W-1 -: DEPTH_W];
    end
    if (s0_valid) begin
      frac_q <= pos[FRAC_W-1:0];
      ok0_q  <= wrapped || (idx0 <= wp);
      ok1_q  <= wrapped || (idx1 <= wp);
    end
    if (s1_valid) begin
      base_q <= {st0, FRAC_W'(0)};
      prod_q <= ip_prod;
    end
    if (in_fire) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + ACC_W'(base_q) + ACC_W'(prod_q);
    end
    if (out_load) begin
      sample_out <= mix_result;
    end
  end

  mcho_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (in_fire),
    .waddr  (wp),
    .wdata  (sample_in),
    .raddr0 (idx0),
    .raddr1 (idx1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  assign mix_req = '{dry: dry_q, sum: acc, voices: voices, mix: mix_lim};

  mcho_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .start  (mix_start),
    .req    (mix_req),
    .done   (mix_done),
    .result (mix_result)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in progress");

  a_voice_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_VOICE |-> VCOUNT_W'(vcnt) < voices)
    else $error("voice counter beyond active voices");

  a_mix_done: assert property (@(posedge clk) disable iff (rst)
    mix_done |-> state == ST_MIX)
    else $error("mix result arrived outside the mix state");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_MIX || state == ST_OUT))
    else $error("output loaded without a finished mix");

endmodule

/* verif/multi_voice_chorus_top_tb.sv */
`timescale 1ns / 1ps

module multi_voice_chorus_top_tb;
  import mcho_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT_ITEM  = 500;
  localparam int PHASE_ITEMS   = 130;
  localparam int PHASE_COUNT   = 7;
  localparam int SHOW_LIMIT    = 10;

  // Chorus predictor: own copy of store, pointer, phases and registers
  class chorus_predictor;
    logic signed [SAMPLE_W-1:0] store [BUFFER_DEPTH];
    logic [ADDR_W-1:0]          wptr;
    logic [PHASE_BITS-1:0]      phase [MAX_VOICES];
    logic signed [SAMPLE_W-1:0] sine_tab [SINE_TABLE_DEPTH];
    logic [VCOUNT_W-1:0]        voice_count;
    logic [PHASE_BITS-1:0]      phase_step;
    logic [DEPTH_W-1:0]         depth_delay;
    logic [MIX_W-1:0]           wet_mix;
    logic signed [SAMPLE_W-1:0] expected_out [$];
    int                         mismatches;
    int                         results_seen;

    function new();
      longint u, quad, t, t2, r, s;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
        u = (longint'(i) * 4 * 65536) / SINE_TABLE_DEPTH;
        quad = (u >>> 16) & 3;
        t = u & 65535;
        // fold the falling quadrants back onto the rising quarter wave
        if (quad == 1 || quad == 3) t = 65536 - t;
        t2 = (t * t) >>> 16;
        r = 5223 - ((307 * t2) >>> 16);
        r = 42334 - ((r * t2) >>> 16);
        r = 102944 - ((r * t2) >>> 16);
        s = (r * t + 65536) >>> 17;
        if (s > 32767) s = 32767;
        sine_tab[i] = SAMPLE_W'((quad >= 2) ? -s : s);
      end
      foreach (store[i]) store[i] = '0;
      wptr = '0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        phase[i] = PHASE_BITS'((longint'(i) << PHASE_BITS) / 6);
      end
      voice_count  = VCOUNT_W'(RST_VOICE_COUNT);
      phase_step   = PHASE_BITS'(RST_PHASE_STEP);
      depth_delay  = DEPTH_W'(RST_DEPTH_DELAY);
      wet_mix      = MIX_W'(RST_WET_MIX);
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_VOICE_COUNT: voice_count = val[VCOUNT_W-1:0];
        REG_PHASE_STEP:  phase_step  = val[PHASE_BITS-1:0];
        REG_DEPTH_DELAY: depth_delay = val[DEPTH_W-1:0];
        REG_WET_MIX:     wet_mix     = val[MIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    // Accepted input item: store it, mix all active voices, advance phases
    function void take_sample(logic signed [SAMPLE_W-1:0] dry_in);
      longint dry, dep, mx, sum, num, den, res, d, p, s;
      int nv, idx, i0, i1, f;
      dry = dry_in;
      store[wptr] = dry_in;
      nv = voice_count;
      if (nv < VOICE_MIN) nv = VOICE_MIN;
      if (nv > VOICE_MAX) nv = VOICE_MAX;
      dep = depth_delay;
      if (dep > DEPTH_MAX) dep = DEPTH_MAX;
      mx = wet_mix;
      if (mx > MIX_ONE) mx = MIX_ONE;
      sum = 0;
      for (int v = 0; v < nv; v++) begin
        idx = int'((longint'(phase[v]) * SINE_TABLE_DEPTH) >> PHASE_BITS);
        s = sine_tab[idx];
        d = (dep * (32768 + s)) >>> 16;
        p = longint'(wptr) * 256 - d;
        if (p < 0) p += longint'(BUFFER_DEPTH) * 256;
        i0 = int'((p >>> 8) % BUFFER_DEPTH);
        f = int'(p & 255);
        i1 = (i0 + 1) % BUFFER_DEPTH;
        sum += longint'(store[i0]) * (256 - f) + longint'(store[i1]) * f;
      end
      den = longint'(nv) * 256 * 32768;
      num = dry * (32768 - mx) * nv * 256 + sum * mx + den / 2;
      res = num / den;
      // round toward minus infinity
      if ((num % den) != 0 && num < 0) res -= 1;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      expected_out.push_back(SAMPLE_W'(res));
      for (int v = 0; v < nv; v++) phase[v] = phase[v] + phase_step;
      wptr = wptr + 1'b1;
    endfunction

    function void compare_output(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      results_seen++;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("result %0d: sample_out %0d with no item pending", results_seen, got);
      end else begin
        want = expected_out.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("result %0d: sample_out expected %0d, actual %0d",
                     results_seen, want, got);
        end
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [PADDR_W-1:0]         paddr;
  logic [PDATA_W-1:0]         pwdata;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  chorus_predictor predictor = new();

  bit idle_on   = 1'b1;
  bit hold_done = 1'b0;
  int items_sent = 0;
  int cycles     = 0;

  logic signed [SAMPLE_W-1:0] extreme_samples [14] = '{
    16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh7fff, 16'sh7fff,
    16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh0000
  };
  logic signed [SAMPLE_W-1:0] swing_samples [8] = '{
    16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'sh0000, 16'sh7f00
  };

  multi_voice_chorus_top dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("multi_voice_chorus_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) predictor.compare_output(sample_out);
  end

  // Receiver: random stalls, plus one long hold-off while items keep coming
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    predictor.set_register(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [PDATA_W-1:0] vc, input logic [PDATA_W-1:0] step,
                           input logic [PDATA_W-1:0] depth, input logic [PDATA_W-1:0] mix);
    reg_write(REG_VOICE_COUNT, vc);
    reg_write(REG_PHASE_STEP, step);
    reg_write(REG_DEPTH_DELAY, depth);
    reg_write(REG_WET_MIX, mix);
  endtask

  // Hold valid high across back-to-back items; drop it only for a gap
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predictor.take_sample(value);
    items_sent++;
  endtask

  // Drain every pending result, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    sample_in <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings, full-scale steps
    foreach (extreme_samples[i]) send_sample(extreme_samples[i]);

    // six voices, phase wraps every item, depth past its limit, mix at one
    settle();
    write_all(6, 24'hffffff, 20'hfffff, MIX_ONE);
    foreach (swing_samples[i]) send_sample(swing_samples[i]);

    // voice count zero, one-sample delay depth, mix above one
    settle();
    write_all(0, 0, 256, 16'hffff);
    repeat (3) send_sample(pick_sample());

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      case (ph)
        0: write_all(2, $urandom_range(1, 2000), 0, 0);
        1: write_all(0, 0, $urandom_range(256, 64 * 256), 16'hffff);
        2: write_all(7, 24'hffffff, DEPTH_MAX, MIX_ONE);
        3: write_all(1, $urandom & 24'hffffff, $urandom_range(0, 200 * 256),
                     $urandom_range(0, MIX_ONE));
        4: write_all(5, $urandom_range(0, 50000), $urandom_range(0, 32 * 256),
                     $urandom & 16'hffff);
        5: write_all($urandom_range(0, 7), $urandom & 24'hffffff, $urandom & 20'hfffff,
                     $urandom & 16'hffff);
        default: begin
          idle_on = 1'b0;
          write_all(4, $urandom_range(100, 5000), $urandom_range(0, 100 * 256),
                    $urandom_range(0, MIX_ONE));
        end
      endcase
      repeat (PHASE_ITEMS) send_sample(pick_sample());
    end

    settle();
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("multi_voice_chorus_top verification clean");
    end else begin
      $display("multi_voice_chorus_top verification failed");
    end
    $finish;
  end

endmodule
